// File: rtl/mvm_pkg.sv
// Shared types, constants and the output saturation function of the matrix-vector unit.
`default_nettype none

package mvm_pkg;

  // The index fields are 4 bits wide, so no more than 16 cells are ever in use.
  localparam int DIM_LIMIT = 16;
  localparam int VAL_W     = 32;
  // 16 products of at most 2^62 in magnitude, plus a sign bit.
  localparam int ACC_W     = 68;

  localparam logic CMD_MAT_WR = 1'b0;
  localparam logic CMD_VEC_WR = 1'b1;

  typedef enum logic [1:0] {
    REG_NUM_ROWS      = 2'd0,
    REG_NUM_COLS      = 2'd1,
    REG_USE_TRANSPOSE = 2'd2
  } mvm_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } mvm_state_t;

  // Token that walks the chain beside its partial sum.
  typedef struct packed {
    logic       valid;
    logic       last;
    logic [3:0] idx;
  } mvm_tok_t;

  // Chain-wide control.
  typedef struct packed {
    logic       adv;
    logic       transpose;
    logic [4:0] inner;
  } mvm_ctl_t;

  // Store write broadcast to every cell.
  typedef struct packed {
    logic                    mat_we;
    logic                    vec_we;
    logic [3:0]              row;
    logic [3:0]              col;
    logic [3:0]              vidx;
    logic signed [VAL_W-1:0] value;
  } mvm_wr_t;

  // Drop 16 fraction bits (floor), then clamp to the signed 32-bit range.
  function automatic logic signed [VAL_W-1:0] sat_q16(input logic [ACC_W-1:0] a);
    logic [ACC_W-48:0] hi;
    hi = a[ACC_W-1:47];
    if ((&hi) || (~|hi)) begin
      return a[47:16];
    end else if (a[ACC_W-1]) begin
      return 32'sh80000000;
    end else begin
      return 32'sh7FFFFFFF;
    end
  endfunction

endpackage

`default_nettype wire

// File: rtl/mvm_cell.sv
// One multiply-accumulate cell of the chain: one vector element, one matrix row and column.
`default_nettype none

module mvm_cell import mvm_pkg::*; #(
  parameter int DIM      = DIM_LIMIT,
  parameter int CELL_IDX = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  mvm_ctl_t         ctl,
  input  mvm_wr_t          wr,
  input  mvm_tok_t         tok_in,
  input  logic [ACC_W-1:0] sum_in,
  output mvm_tok_t         tok_out,
  output logic [ACC_W-1:0] sum_out
);

  localparam int AW = $clog2(DIM);

  // col_mem holds matrix column CELL_IDX (by row), row_mem holds row CELL_IDX (by column).
  logic signed [VAL_W-1:0] col_mem [DIM];
  logic signed [VAL_W-1:0] row_mem [DIM];
  logic signed [VAL_W-1:0] vec;

  mvm_tok_t                tok1;
  mvm_tok_t                tok2;
  logic signed [VAL_W-1:0] rd_col;
  logic signed [VAL_W-1:0] rd_row;
  logic signed [VAL_W-1:0] mul_a;
  logic signed [63:0]      prod;
  logic [ACC_W-1:0]        sum1;
  logic [ACC_W-1:0]        sum2;
  logic [AW-1:0]           rd_addr;
  logic                    col_we;
  logic                    row_we;
  logic                    vec_we;
  logic                    active;

  assign rd_addr = tok_in.idx[AW-1:0];
  assign col_we  = wr.mat_we && (wr.col == 4'(CELL_IDX)) && ({1'b0, wr.row} < 5'(DIM));
  assign row_we  = wr.mat_we && (wr.row == 4'(CELL_IDX)) && ({1'b0, wr.col} < 5'(DIM));
  assign vec_we  = wr.vec_we && (wr.vidx == 4'(CELL_IDX));
  assign active  = (5'(CELL_IDX) < ctl.inner);
  assign mul_a   = ctl.transpose ? rd_row : rd_col;

  always_ff @(posedge clk) begin
    if (col_we) begin
      col_mem[wr.row[AW-1:0]] <= wr.value;
    end
    if (row_we) begin
      row_mem[wr.col[AW-1:0]] <= wr.value;
    end
    if (vec_we) begin
      vec <= wr.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok1    <= '0;
      tok2    <= '0;
      tok_out <= '0;
    end else if (ctl.adv) begin
      tok1    <= tok_in;
      tok2    <= tok1;
      tok_out <= tok2;
    end
  end

  // Read, multiply, add: three stages, all held while the chain is frozen.
  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      rd_col  <= col_mem[rd_addr];
      rd_row  <= row_mem[rd_addr];
      sum1    <= sum_in;
      prod    <= active ? (mul_a * vec) : 64'sd0;
      sum2    <= sum1;
      sum_out <= sum2 + {{(ACC_W-64){prod[63]}}, prod};
    end
  end

endmodule

`default_nettype wire

// File: rtl/mvm_seq.sv
// Run sequencer: issues one output index per cycle while not frozen; tracks the busy window.
`default_nettype none

module mvm_seq import mvm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       adv,
  input  logic [4:0] outer,
  input  logic       done,
  output logic       busy,
  output mvm_tok_t   tok
);

  mvm_state_t state;
  mvm_state_t state_next;
  logic [3:0] cnt;
  logic       issue_last;

  assign issue_last = ((5'(cnt) + 5'd1) == outer);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (start) state_next = ST_ISSUE;
      ST_ISSUE: if (adv && issue_last) state_next = ST_DRAIN;
      ST_DRAIN: if (done) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy = 1'b1;
    tok  = '0;
    unique case (state)
      ST_IDLE:  busy = 1'b0;
      ST_ISSUE: begin
        tok.valid = 1'b1;
        tok.last  = issue_last;
        tok.idx   = cnt;
      end
      ST_DRAIN: busy = 1'b1;
      default:  busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE) begin
        cnt <= '0;
      end else if (state == ST_ISSUE && adv) begin
        cnt <= cnt + 4'd1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/matrix_vector_multiply_unit.sv
// Top level of the matrix-vector multiply unit: config port, chain of MAC cells, output stage.
`default_nettype none

// Dense matrix-vector multiply in signed Q16.16. Each input beat writes one
// matrix element (cmd 0) or one vector element (cmd 1). A vector beat with
// start_compute set launches a run that returns one result beat per row (per
// column when use_transpose is set), in increasing index order, with
// last_result on the final one. The work is done by a chain of
// D = min(MAX_DIM, 16) cells: cell j owns vector element j plus row j and
// column j of the matrix, so the partial sum of one result walks the chain
// and picks up one product in each cell. Each cell is three register stages
// deep (store read, multiply, add). After the first result beat of a run the
// rest follow one per cycle while the result side does not stall; a stall
// on the result side freezes the whole chain. Input is stalled from the
// cycle after the start beat until the last result beat is taken. Sums are
// exact; each is floored to Q16.16 and saturated on the way out. Matrix and
// vector entries that were never written read as garbage. Registers (APB,
// byte addresses 0, 4, 8): num_rows, num_cols, use_transpose; dimensions are
// clamped to 1..min(MAX_DIM,16).
// Write them only while no run is in flight.

module matrix_vector_multiply_unit import mvm_pkg::*; #(
  parameter int MAX_DIM = DIM_LIMIT
) (
  input  logic                    clk,
  input  logic                    rst,
  // APB configuration port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [3:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  // input items
  input  logic                    item_valid,
  output logic                    item_stall,
  input  logic                    cmd,
  input  logic [3:0]              row_index,
  input  logic [3:0]              col_index,
  input  logic [3:0]              vec_index,
  input  logic signed [VAL_W-1:0] value,
  input  logic                    start_compute,
  // results
  output logic                    result_valid,
  input  logic                    result_stall,
  output logic signed [VAL_W-1:0] result_value,
  output logic [3:0]              result_index,
  output logic                    last_result
);

  localparam int DIM = (MAX_DIM < DIM_LIMIT) ? MAX_DIM : DIM_LIMIT;

  logic [4:0]       num_rows;
  logic [4:0]       num_cols;
  logic             use_transpose;
  logic             cfg_wr;
  logic [4:0]       nr;
  logic [4:0]       nc;
  logic [4:0]       outer;
  logic             item_acc;
  logic             start;
  logic             done;
  logic             busy;
  logic             adv;
  mvm_ctl_t         ctl;
  mvm_wr_t          wr;
  mvm_tok_t         tok   [DIM+1];
  logic [ACC_W-1:0] sums  [DIM+1];

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows      <= 5'd16;
      num_cols      <= 5'd16;
      use_transpose <= 1'b0;
    end else if (cfg_wr) begin
      unique case (mvm_reg_t'(paddr[3:2]))
        REG_NUM_ROWS:      num_rows      <= pwdata[4:0];
        REG_NUM_COLS:      num_cols      <= pwdata[4:0];
        REG_USE_TRANSPOSE: use_transpose <= pwdata[0];
        default:           ;
      endcase
    end
  end

  always_comb begin
    unique case (mvm_reg_t'(paddr[3:2]))
      REG_NUM_ROWS:      prdata = {27'd0, num_rows};
      REG_NUM_COLS:      prdata = {27'd0, num_cols};
      REG_USE_TRANSPOSE: prdata = {31'd0, use_transpose};
      default:           prdata = '0;
    endcase
  end

  // Clamp both dimensions to 1..DIM; zero acts as one.
  always_comb begin
    nr = num_rows;
    if (num_rows == 5'd0) begin
      nr = 5'd1;
    end else if (num_rows > 5'(DIM)) begin
      nr = 5'(DIM);
    end
    nc = num_cols;
    if (num_cols == 5'd0) begin
      nc = 5'd1;
    end else if (num_cols > 5'(DIM)) begin
      nc = 5'(DIM);
    end
  end

  assign outer = use_transpose ? nc : nr;

  // ---------------------------------------------------------------- input side
  // Store writes only happen while no run is in flight, so the chain never
  // reads an entry that is changing under it.
  assign item_stall = busy;
  assign item_acc   = item_valid && !item_stall;
  assign start      = item_acc && (cmd == CMD_VEC_WR) && start_compute;

  always_comb begin
    wr.mat_we = item_acc && (cmd == CMD_MAT_WR);
    wr.vec_we = item_acc && (cmd == CMD_VEC_WR);
    wr.row    = row_index;
    wr.col    = col_index;
    wr.vidx   = vec_index;
    wr.value  = value;
  end

  // ---------------------------------------------------------------- chain
  // Freeze every stage while a finished result is waiting on a stalled sink.
  assign adv = !(result_valid && result_stall);

  always_comb begin
    ctl.adv       = adv;
    ctl.transpose = use_transpose;
    ctl.inner     = use_transpose ? nr : nc;
  end

  assign done = result_valid && !result_stall && last_result;

  mvm_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .adv   (adv),
    .outer (outer),
    .done  (done),
    .busy  (busy),
    .tok   (tok[0])
  );

  assign sums[0] = '0;

  for (genvar j = 0; j < DIM; j++) begin : g_cell
    mvm_cell #(
      .DIM      (DIM),
      .CELL_IDX (j)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .wr      (wr),
      .tok_in  (tok[j]),
      .sum_in  (sums[j]),
      .tok_out (tok[j+1]),
      .sum_out (sums[j+1])
    );
  end

  // ---------------------------------------------------------------- output stage
  // Floor and saturate the finished sum; hold the beat while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= tok[DIM].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result_value <= sat_q16(sums[DIM]);
      result_index <= tok[DIM].idx;
      last_result  <= tok[DIM].last;
    end
  end

  // ---------------------------------------------------------------- checks
  // A start beat always closes the input side on the next cycle.
  a_start_blocks: assert property (@(posedge clk) disable iff (rst)
    start |=> item_stall)
    else $error("input not stalled after a start beat");

  // Taking the final result reopens the input side.
  a_done_reopens: assert property (@(posedge clk) disable iff (rst)
    done |=> !item_stall)
    else $error("input still stalled after the last result beat");

  // Results only exist inside a run.
  a_result_in_run: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> item_stall)
    else $error("result beat presented outside a run");

endmodule

`default_nettype wire

// File: verif/tb_matrix_vector_multiply_unit.sv
// Self-checking bench for the matrix-vector unit: directed and random traffic against a predictor.
`timescale 1ns / 100ps

module tb_matrix_vector_multiply_unit import mvm_pkg::*;;

  localparam int HALF_PERIOD   = 6;
  // Exceeds the chain depth with margin, so stray work is done.
  localparam int SETTLE_CYCLES = 3 * DIM_LIMIT + 16;
  // Long result-side hold-off, well past the time a 16-result run needs.
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_BEATS  = 280;

  // Saturation bounds of a floored Q16.16 sum.
  localparam logic signed [71:0] Q16_MAX = 72'sh0_7FFF_FFFF;
  localparam logic signed [71:0] Q16_MIN = -72'sh0_8000_0000;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_phase_t;

  // One load beat: a matrix element or a vector element.
  typedef struct {
    logic                    cmd;
    logic [3:0]              row;
    logic [3:0]              col;
    logic [3:0]              vidx;
    logic signed [VAL_W-1:0] value;
    logic                    start;
  } load_beat_t;

  // One dot product as the unit should return it.
  typedef struct {
    logic signed [VAL_W-1:0] value;
    logic [3:0]              index;
    logic                    last;
  } dot_result_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [3:0]              paddr = '0;
  logic [31:0]             pwdata = '0;
  logic [31:0]             prdata;
  logic                    pready;
  logic                    item_valid = 1'b0;
  logic                    item_stall;
  logic                    cmd = CMD_MAT_WR;
  logic [3:0]              row_index = '0;
  logic [3:0]              col_index = '0;
  logic [3:0]              vec_index = '0;
  logic signed [VAL_W-1:0] value = '0;
  logic                    start_compute = 1'b0;
  logic                    result_valid;
  logic                    result_stall = 1'b0;
  logic signed [VAL_W-1:0] result_value;
  logic [3:0]              result_index;
  logic                    last_result;

  // Mirror of the unit's stores and registers, plus which entries hold data.
  logic signed [VAL_W-1:0] mat_mirror [DIM_LIMIT][DIM_LIMIT];
  logic signed [VAL_W-1:0] vec_mirror [DIM_LIMIT];
  bit                      mat_loaded [DIM_LIMIT][DIM_LIMIT];
  bit                      vec_loaded [DIM_LIMIT];
  logic [4:0]              rows_cfg = 5'd16;
  logic [4:0]              cols_cfg = 5'd16;
  logic                    transpose_cfg = 1'b0;

  dot_result_t pending_dots[$];

  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int hold_asks       = 0;
  int hold_seen       = 0;
  int hold_left       = 0;
  int cycle_count     = 0;
  int mismatches      = 0;
  int beats_sent      = 0;
  int runs_launched   = 0;
  int dots_checked    = 0;
  int shapes_set      = 0;

  matrix_vector_multiply_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .cmd           (cmd),
    .row_index     (row_index),
    .col_index     (col_index),
    .vec_index     (vec_index),
    .value         (value),
    .start_compute (start_compute),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result_value  (result_value),
    .result_index  (result_index),
    .last_result   (last_result)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d results still expected",
             cycle_count, pending_dots.size());
      $display("tb_matrix_vector_multiply_unit NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Dimension registers act as 1..16; zero reads as one, oversize as sixteen.
  function automatic int eff_dim(input logic [4:0] d);
    if (d == 5'd0) return 1;
    if (d > 5'(DIM_LIMIT)) return DIM_LIMIT;
    return int'(d);
  endfunction

  // Queue one dot product per row (per column when transposed). Sums are kept
  // exact at 72 bits, floored by an arithmetic shift, then clamped.
  task automatic predict_dot_products();
    int                      outer_n;
    int                      inner_n;
    int                      i;
    int                      j;
    logic signed [VAL_W-1:0] m;
    logic signed [63:0]      prod;
    logic signed [71:0]      acc;
    logic signed [71:0]      floored;
    dot_result_t             d;
    outer_n = transpose_cfg ? eff_dim(cols_cfg) : eff_dim(rows_cfg);
    inner_n = transpose_cfg ? eff_dim(rows_cfg) : eff_dim(cols_cfg);
    for (i = 0; i < outer_n; i++) begin
      acc = '0;
      for (j = 0; j < inner_n; j++) begin
        m    = transpose_cfg ? mat_mirror[j][i] : mat_mirror[i][j];
        prod = m * vec_mirror[j];
        acc  = acc + prod;
      end
      floored = acc >>> 16;
      if (floored > Q16_MAX) begin
        d.value = 32'sh7FFF_FFFF;
      end else if (floored < Q16_MIN) begin
        d.value = 32'sh8000_0000;
      end else begin
        d.value = floored[31:0];
      end
      d.index = 4'(i);
      d.last  = (i == outer_n - 1);
      pending_dots.push_back(d);
    end
  endtask

  // Apply one accepted beat to the mirror; a flagged vector beat starts a run.
  task automatic mirror_load(input load_beat_t b);
    if (b.cmd == CMD_MAT_WR) begin
      mat_mirror[b.row][b.col] = b.value;
      mat_loaded[b.row][b.col] = 1'b1;
    end else begin
      vec_mirror[b.vidx] = b.value;
      vec_loaded[b.vidx] = 1'b1;
      if (b.start) predict_dot_products();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: check each accepted beat, then decide next cycle's stall.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    dot_result_t want;
    if (!rst && result_valid === 1'b1 && result_stall == 1'b0) begin
      if (pending_dots.size() == 0) begin
        $error("result beat with nothing expected: result_value %h, result_index %0d",
               result_value, result_index);
        mismatches++;
      end else begin
        want = pending_dots.pop_front();
        dots_checked++;
        if (result_value !== want.value) begin
          $error("result_value: expected %h, got %h", want.value, result_value);
          mismatches++;
        end
        if (result_index !== want.index) begin
          $error("result_index: expected %0d, got %0d", want.index, result_index);
          mismatches++;
        end
        if (last_result !== want.last) begin
          $error("last_result: expected %0b, got %0b", want.last, last_result);
          mismatches++;
        end
      end
    end
    // A hold request from the test overrides random stalling for a while.
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic set_idle_phase(input idle_phase_t p);
    sender_idle_pct = (p == IDLE_SENDER) ? 54 : (p == IDLE_BOTH) ? 9 : 0;
    recv_stall_pct  = (p == IDLE_RECEIVER) ? 54 : (p == IDLE_BOTH) ? 9 : 0;
  endtask

  function automatic load_beat_t mat_beat(input logic [3:0] r, input logic [3:0] c,
                                          input logic signed [VAL_W-1:0] v,
                                          input logic flag);
    load_beat_t b;
    b.cmd   = CMD_MAT_WR;
    b.row   = r;
    b.col   = c;
    b.vidx  = 4'($urandom_range(15));
    b.value = v;
    b.start = flag;
    return b;
  endfunction

  function automatic load_beat_t vec_beat(input logic [3:0] idx,
                                          input logic signed [VAL_W-1:0] v,
                                          input logic flag);
    load_beat_t b;
    b.cmd   = CMD_VEC_WR;
    b.row   = 4'($urandom_range(15));
    b.col   = 4'($urandom_range(15));
    b.vidx  = idx;
    b.value = v;
    b.start = flag;
    return b;
  endfunction

  // Mix of small fractions, full-range words, exact extremes and values whose
  // products land near the Q16.16 saturation boundary.
  function automatic logic signed [VAL_W-1:0] pick_q16();
    int unsigned             sel;
    logic signed [VAL_W-1:0] mag;
    sel = $urandom_range(99);
    if (sel < 30) return $urandom();
    if (sel < 70) return 32'($urandom_range(32'h0008_0000)) - 32'h0004_0000;
    if (sel < 85) begin
      case ($urandom_range(6))
        0:       return 32'sh7FFF_FFFF;
        1:       return 32'sh8000_0000;
        2:       return 32'sh0001_0000;
        3:       return -32'sh0001_0000;
        4:       return 32'sh0000_0001;
        5:       return -32'sh0000_0001;
        default: return '0;
      endcase
    end
    mag = 32'($urandom_range(32'h0180_0000, 32'h0040_0000));
    return $urandom_range(1) ? mag : -mag;
  endfunction

  // Mostly small shapes; a few full-size and out-of-range register values.
  function automatic logic [4:0] pick_dim();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 70) return 5'($urandom_range(4, 1));
    if (sel < 90) return 5'($urandom_range(16, 5));
    if (sel < 95) return 5'd0;
    return 5'($urandom_range(31, 17));
  endfunction

  // Offer one beat, hold its payload until accepted, then update the mirror.
  // Valid stays high on return; the next call or a drain decides what follows.
  task automatic send_beat(input load_beat_t b);
    while ($urandom_range(99) < sender_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid    <= 1'b1;
    cmd           <= b.cmd;
    row_index     <= b.row;
    col_index     <= b.col;
    vec_index     <= b.vidx;
    value         <= b.value;
    start_compute <= b.start;
    @(posedge clk);
    while (item_stall !== 1'b0) @(posedge clk);
    mirror_load(b);
    beats_sent++;
  endtask

  // Drop valid, wait for every expected result, then let the chain go quiet.
  task automatic drain_and_settle();
    item_valid <= 1'b0;
    while (pending_dots.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Setup cycle then access cycle; psel stays up between back-to-back writes.
  task automatic apb_write(input mvm_reg_t idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
  endtask

  // Read one register back in a setup and an access cycle and compare it.
  task automatic apb_read_check(input mvm_reg_t idx, input logic [31:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    if (prdata !== want) begin
      $error("prdata: expected %h, got %h", want, prdata);
      mismatches++;
    end
  endtask

  // Write all three registers and read them back; call only while idle.
  task automatic program_shape(input logic [4:0] rows, input logic [4:0] cols,
                               input logic tr);
    apb_write(REG_NUM_ROWS, 32'(rows));
    apb_write(REG_NUM_COLS, 32'(cols));
    apb_write(REG_USE_TRANSPOSE, 32'(tr));
    apb_read_check(REG_NUM_ROWS, 32'(rows));
    apb_read_check(REG_NUM_COLS, 32'(cols));
    apb_read_check(REG_USE_TRANSPOSE, 32'(tr));
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    rows_cfg      = rows;
    cols_cfg      = cols;
    transpose_cfg = tr;
    shapes_set++;
  endtask

  // Load every entry the next run reads that has never been written, so the
  // unit never multiplies an uninitialized store word into a sum.
  task automatic load_missing_entries();
    int nr;
    int nc;
    int vlen;
    int r;
    int c;
    nr   = eff_dim(rows_cfg);
    nc   = eff_dim(cols_cfg);
    vlen = transpose_cfg ? nr : nc;
    for (r = 0; r < nr; r++) begin
      for (c = 0; c < nc; c++) begin
        if (!mat_loaded[r][c]) send_beat(mat_beat(4'(r), 4'(c), pick_q16(), 1'b0));
      end
    end
    for (r = 0; r < vlen; r++) begin
      if (!vec_loaded[r]) send_beat(vec_beat(4'(r), pick_q16(), 1'b0));
    end
  endtask

  // Load any missing entries, then send the final vector beat of a run.
  task automatic launch_product(input logic [3:0] idx, input logic signed [VAL_W-1:0] v);
    load_missing_entries();
    send_beat(vec_beat(idx, v, 1'b1));
    runs_launched++;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Rows built to land exactly on and just past both saturation
  // limits, plus a tiny negative sum that must floor to -1 LSB.
  task automatic test_saturation_edges();
    logic signed [VAL_W-1:0] col0 [5];
    logic signed [VAL_W-1:0] col1 [5];
    int                      r;
    col0 = '{32'sh0080_0000, 32'sh0080_0000, -32'sh0080_0000, -32'sh0080_0000, 32'sh0};
    col1 = '{32'sh0, -32'sh1, 32'sh0, -32'sh1, -32'sh1};
    set_idle_phase(IDLE_NONE);
    program_shape(5'd5, 5'd2, 1'b0);
    for (r = 0; r < 5; r++) begin
      send_beat(mat_beat(4'(r), 4'd0, col0[r], 1'b0));
      send_beat(mat_beat(4'(r), 4'd1, col1[r], 1'b0));
    end
    send_beat(vec_beat(4'd0, 32'sh0100_0000, 1'b0));
    launch_product(4'd1, 32'sh0000_0001);
    drain_and_settle();
  endtask

  // Transposed product over the same matrix; a start flag on a matrix beat
  // must not launch a run, and writes at the top indexes must be harmless.
  task automatic test_transpose_and_stray_flag();
    program_shape(5'd5, 5'd2, 1'b1);
    send_beat(mat_beat(4'd15, 4'd15, 32'sh7FFF_FFFF, 1'b1));
    send_beat(vec_beat(4'd15, 32'sh8000_0000, 1'b0));
    send_beat(vec_beat(4'd2, pick_q16(), 1'b0));
    send_beat(vec_beat(4'd3, pick_q16(), 1'b0));
    launch_product(4'd4, pick_q16());
    drain_and_settle();
  endtask

  // Zero in both dimension registers acts as a 1x1 matrix, either orientation.
  task automatic test_zero_dims();
    program_shape(5'd0, 5'd0, 1'b0);
    launch_product(4'd0, 32'sh0002_0000);
    drain_and_settle();
    program_shape(5'd0, 5'd0, 1'b1);
    launch_product(4'd0, -32'sh0003_8000);
    drain_and_settle();
  endtask

  // Fill the whole 16x16 matrix with extreme words so every sum overflows the
  // output range, then hold the result side off for a long stretch while the
  // sender keeps offering beats: the unit fills up and stalls its input.
  task automatic test_full_size_pressure();
    int r;
    int c;
    set_idle_phase(IDLE_NONE);
    program_shape(5'd16, 5'd16, 1'b0);
    for (r = 0; r < DIM_LIMIT; r++) begin
      for (c = 0; c < DIM_LIMIT; c++) begin
        send_beat(mat_beat(4'(r), 4'(c), r[0] ? 32'sh7FFF_FFFF : 32'sh8000_0000, 1'b0));
      end
    end
    for (r = 0; r < DIM_LIMIT - 1; r++) send_beat(vec_beat(4'(r), 32'sh8000_0000, 1'b0));
    hold_asks++;
    launch_product(4'd15, 32'sh8000_0000);
    // Keep offering: these beats sit stalled until the held run drains.
    repeat (16) begin
      send_beat(mat_beat(4'd0, 4'($urandom_range(15)), pick_q16(), 1'b0));
    end
    launch_product(4'($urandom_range(15)), pick_q16());
    drain_and_settle();
    // Oversize registers clamp to 16; transposed sums mostly cancel.
    set_idle_phase(IDLE_BOTH);
    program_shape(5'd31, 5'd31, 1'b1);
    launch_product(4'd15, 32'sh8000_0000);
    drain_and_settle();
  endtask

  // Random load sequences with random shapes, moving through every idling
  // phase and ending on a stretch with no idling at all.
  task automatic test_random_traffic();
    int          first;
    int          body;
    int          step;
    int unsigned sel;
    first = beats_sent;
    while (beats_sent - first < RANDOM_BEATS) begin
      step = ((beats_sent - first) * 5) / RANDOM_BEATS;
      set_idle_phase(step >= 4 ? IDLE_NONE : idle_phase_t'(step));
      if ($urandom_range(2) == 0) begin
        drain_and_settle();
        program_shape(pick_dim(), pick_dim(), 1'($urandom_range(1)));
      end
      body = $urandom_range(10);
      repeat (body) begin
        sel = $urandom_range(99);
        if (sel < 45) begin
          send_beat(mat_beat(4'($urandom_range(15)), 4'($urandom_range(15)),
                             pick_q16(), 1'b0));
        end else if (sel < 85) begin
          send_beat(vec_beat(4'($urandom_range(15)), pick_q16(), 1'b0));
        end else begin
          // Noise: start flag on a matrix beat launches nothing.
          send_beat(mat_beat(4'($urandom_range(15)), 4'($urandom_range(15)),
                             pick_q16(), 1'b1));
        end
      end
      launch_product(4'($urandom_range(15)), pick_q16());
    end
    drain_and_settle();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_saturation_edges();
    test_transpose_and_stray_flag();
    test_zero_dims();
    test_full_size_pressure();
    test_random_traffic();
    if (pending_dots.size() != 0) begin
      $error("%0d expected results never arrived", pending_dots.size());
    end
    $display("Run covered %0d load beats, %0d product runs, %0d result beats checked, %0d shapes.",
             beats_sent, runs_launched, dots_checked, shapes_set);
    $display("Both orientations, saturation both ways, clamped dimensions, long result hold-off.");
    if (mismatches == 0 && pending_dots.size() == 0) begin
      $display("tb_matrix_vector_multiply_unit OK");
    end else begin
      $display("tb_matrix_vector_multiply_unit NOT OK");
    end
    $finish;
  end

endmodule
